// ----- hw/rtl/plcl_pkg.sv -----
// Shared constants and field widths for the piecewise-linear color lookup table.
package plcl_pkg;

    // Default sizing, handed to the top level parameters
    localparam int DEF_MAX_POINTS = 32;
    localparam int DEF_MAX_DOMAIN = 4096;
    localparam int DEF_CHANNELS   = 4;

    // Field widths
    localparam int X_W      = 13;            // point x
    localparam int Y_W      = 17;            // point y, Q1.16
    localparam int IDX_W    = 12;            // evaluate index
    localparam int DX_W     = 12;            // index minus segment start
    localparam int DY_W     = Y_W + 1;       // signed y difference
    localparam int PROD_W   = DX_W + Y_W;    // magnitude of dx * dy
    localparam int SLOT_W   = 5;
    localparam int CH_W     = 2;
    localparam int NUM_CH   = 4;             // value fields on the result bus
    localparam int DOM_W    = 13;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 13;
    localparam int ST_W     = 2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;

    localparam logic [Y_W-1:0] Y_MAX = Y_W'(65536);

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_WRITTEN = 2'd0;
    localparam logic [ST_W-1:0] ST_VALID   = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_ALPHA = 3'd4;

endpackage

// ----- hw/rtl/piecewise_linear_color_lut.sv -----
// Top level of the piecewise-linear color lookup table: point store, segment walk, results.
//
//  channel   direction  handshake          contents
//  s_        in         s_tvalid/s_tready  write point or evaluate index
//  m_        out        m_tvalid/m_tready  status and four channel values
//  cfg_      in         cfg_we             domain size and per-channel point counts
//
// A point write or an out-of-range request is answered straight from idle. An
// evaluation walks each channel's points through the single read port of the
// point memory and, where a segment matches, runs the shared multiply/divide
// unit before it moves on to the next channel.
// Reset is synchronous and active low; the point memory is not cleared.
// The block takes no new item until its last result has been taken.
module piecewise_linear_color_lut #(
    parameter int MAX_POINTS = plcl_pkg::DEF_MAX_POINTS,
    parameter int MAX_DOMAIN = plcl_pkg::DEF_MAX_DOMAIN,
    parameter int CHANNELS   = plcl_pkg::DEF_CHANNELS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel[1:0], slot[6:2], point_x[19:7], point_y[36:20], eval_index[48:37], zero pad
    input  logic [plcl_pkg::IN_TDATA_W-1:0]     s_tdata,
    // req_type[0]
    input  logic                                s_tuser,
    // result out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // value_red[16:0], value_green[33:17], value_blue[50:34], value_alpha[67:51], zero pad
    output logic [plcl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [plcl_pkg::ST_W-1:0]           m_tuser,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [plcl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plcl_pkg::CFG_W-1:0]          cfg_data
);

    localparam int DEPTH = CHANNELS * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_POINTS);
    localparam int PC_W  = $clog2(MAX_POINTS + 1);
    localparam int MW    = plcl_pkg::X_W + plcl_pkg::Y_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_MATH = 2'd2;
    localparam logic [1:0] S_NEXT = 2'd3;

    // Input fields
    logic [plcl_pkg::CH_W-1:0]   in_channel;
    logic [plcl_pkg::SLOT_W-1:0] in_slot;
    logic [plcl_pkg::X_W-1:0]    in_x;
    logic [plcl_pkg::Y_W-1:0]    in_y;
    logic [plcl_pkg::IDX_W-1:0]  in_index;

    assign in_channel = s_tdata[1:0];
    assign in_slot    = s_tdata[6:2];
    assign in_x       = s_tdata[19:7];
    assign in_y       = s_tdata[36:20];
    assign in_index   = s_tdata[48:37];

    // Point memory, {x, y} per entry
    logic [MW-1:0] mem [DEPTH];
    logic [MW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [MW-1:0] wr_data;

    // Configuration
    logic [plcl_pkg::DOM_W-1:0] dom_reg;
    logic [plcl_pkg::CNT_W-1:0] cnt_reg [plcl_pkg::NUM_CH];

    // Sequencer state
    logic [1:0]                  state_reg, state_next;
    logic [plcl_pkg::CH_W-1:0]   ch_reg, ch_next;
    logic [AW-1:0]               base_reg, base_next;
    logic [PC_W-1:0]             issue_reg, issue_next;
    logic [PC_W-1:0]             n_reg, n_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        rd_k0_reg, rd_k0_next;
    logic [plcl_pkg::X_W-1:0]    prev_x_reg, prev_x_next;
    logic [plcl_pkg::Y_W-1:0]    prev_y_reg, prev_y_next;
    logic                        seg_found_reg, seg_found_next;
    logic [plcl_pkg::DX_W-1:0]   seg_dxi_reg, seg_dxi_next;
    logic [plcl_pkg::X_W-1:0]    seg_dx_reg, seg_dx_next;
    logic signed [plcl_pkg::DY_W-1:0] seg_dy_reg, seg_dy_next;
    logic [plcl_pkg::Y_W-1:0]    seg_ya_reg, seg_ya_next;
    logic [plcl_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [plcl_pkg::Y_W-1:0]    val_reg [plcl_pkg::NUM_CH];
    logic [plcl_pkg::Y_W-1:0]    val_next [plcl_pkg::NUM_CH];
    logic                        m_valid_reg, m_valid_next;
    logic [plcl_pkg::ST_W-1:0]   m_status_reg, m_status_next;

    // Interpolation unit
    logic                        unit_start;
    logic                        unit_done;
    logic [plcl_pkg::Y_W-1:0]    unit_value;

    logic                        in_fire;
    logic [plcl_pkg::X_W-1:0]    cur_x;
    logic [plcl_pkg::Y_W-1:0]    cur_y;
    logic [plcl_pkg::X_W-1:0]    idx_ext;
    logic                        seg_hit;
    logic                        walk_end;
    logic                        slot_bad;
    logic                        index_bad;

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0, val_reg[3], val_reg[2], val_reg[1], val_reg[0]};

    // Range checks on the request
    assign slot_bad  = (32'(in_slot) >= MAX_POINTS) || (32'(in_channel) >= CHANNELS);
    assign index_bad = ({1'b0, in_index} >= dom_reg) || (32'(in_index) >= MAX_DOMAIN);

    // Point write path
    assign wr_en   = in_fire && (s_tuser == plcl_pkg::REQ_WRITE) && !slot_bad;
    assign wr_addr = AW'(32'(in_channel) * MAX_POINTS + 32'(in_slot));
    assign wr_data = {in_x, (in_y > plcl_pkg::Y_MAX) ? plcl_pkg::Y_MAX : in_y};
    assign rd_addr = base_reg + AW'(issue_reg[KW-1:0]);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Segment test on the point just read against the one before it
    assign cur_x    = rd_data_reg[MW-1:plcl_pkg::Y_W];
    assign cur_y    = rd_data_reg[plcl_pkg::Y_W-1:0];
    assign idx_ext  = {1'b0, idx_reg};
    assign seg_hit  = rd_valid_reg && !rd_k0_reg && (cur_x > prev_x_reg)
                      && (idx_ext >= prev_x_reg) && (idx_ext < cur_x);
    assign walk_end = (issue_reg == n_reg) && !rd_valid_reg;

    assign unit_start = (state_reg == S_WALK) && walk_end && seg_found_reg;

    function automatic logic [PC_W-1:0] sat_count(input logic [plcl_pkg::CNT_W-1:0] c);
        return (32'(c) > MAX_POINTS) ? PC_W'(MAX_POINTS) : PC_W'(c);
    endfunction

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dom_reg <= plcl_pkg::DOM_W'(256);
            for (int i = 0; i < plcl_pkg::NUM_CH; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                plcl_pkg::REG_DOMAIN:      dom_reg    <= cfg_data;
                plcl_pkg::REG_COUNT_RED:   cnt_reg[0] <= cfg_data[plcl_pkg::CNT_W-1:0];
                plcl_pkg::REG_COUNT_GREEN: cnt_reg[1] <= cfg_data[plcl_pkg::CNT_W-1:0];
                plcl_pkg::REG_COUNT_BLUE:  cnt_reg[2] <= cfg_data[plcl_pkg::CNT_W-1:0];
                plcl_pkg::REG_COUNT_ALPHA: cnt_reg[3] <= cfg_data[plcl_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        base_next      = base_reg;
        issue_next     = issue_reg;
        n_next         = n_reg;
        rd_valid_next  = 1'b0;
        rd_k0_next     = rd_k0_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        seg_found_next = seg_found_reg;
        seg_dxi_next   = seg_dxi_reg;
        seg_dx_next    = seg_dx_reg;
        seg_dy_next    = seg_dy_reg;
        seg_ya_next    = seg_ya_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        for (int i = 0; i < plcl_pkg::NUM_CH; i++) begin
            val_next[i] = val_reg[i];
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    for (int i = 0; i < plcl_pkg::NUM_CH; i++) begin
                        val_next[i] = '0;
                    end
                    idx_next = in_index;
                    if (s_tuser == plcl_pkg::REQ_WRITE) begin
                        m_valid_next  = 1'b1;
                        m_status_next = slot_bad ? plcl_pkg::ST_RANGE : plcl_pkg::ST_WRITTEN;
                    end else if (index_bad) begin
                        m_valid_next  = 1'b1;
                        m_status_next = plcl_pkg::ST_RANGE;
                    end else begin
                        ch_next        = '0;
                        base_next      = '0;
                        issue_next     = '0;
                        n_next         = sat_count(cnt_reg[0]);
                        seg_found_next = 1'b0;
                        state_next     = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Issue one read a cycle
                if (issue_reg != n_reg) begin
                    issue_next    = issue_reg + 1'b1;
                    rd_valid_next = 1'b1;
                    rd_k0_next    = (issue_reg == '0);
                end
                // Consume the point read last cycle; the highest matching slot wins
                if (rd_valid_reg) begin
                    if (seg_hit) begin
                        seg_found_next = 1'b1;
                        seg_dxi_next   = plcl_pkg::DX_W'(idx_ext - prev_x_reg);
                        seg_dx_next    = cur_x - prev_x_reg;
                        seg_dy_next    = $signed({1'b0, cur_y}) - $signed({1'b0, prev_y_reg});
                        seg_ya_next    = prev_y_reg;
                    end
                    prev_x_next = cur_x;
                    prev_y_next = cur_y;
                end
                if (walk_end) begin
                    state_next = seg_found_reg ? S_MATH : S_NEXT;
                end
            end
            S_MATH: begin
                if (unit_done) begin
                    val_next[ch_reg] = unit_value;
                    state_next       = S_NEXT;
                end
            end
            S_NEXT: begin
                if (32'(ch_reg) == CHANNELS - 1) begin
                    m_valid_next  = 1'b1;
                    m_status_next = plcl_pkg::ST_VALID;
                    state_next    = S_IDLE;
                end else begin
                    ch_next        = ch_reg + 1'b1;
                    base_next      = base_reg + AW'(MAX_POINTS);
                    issue_next     = '0;
                    n_next         = sat_count(cnt_reg[ch_reg + 1'b1]);
                    seg_found_next = 1'b0;
                    state_next     = S_WALK;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= rd_valid_next;
        end
        ch_reg        <= ch_next;
        base_reg      <= base_next;
        issue_reg     <= issue_next;
        n_reg         <= n_next;
        rd_k0_reg     <= rd_k0_next;
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        seg_found_reg <= seg_found_next;
        seg_dxi_reg   <= seg_dxi_next;
        seg_dx_reg    <= seg_dx_next;
        seg_dy_reg    <= seg_dy_next;
        seg_ya_reg    <= seg_ya_next;
        idx_reg       <= idx_next;
        m_status_reg  <= m_status_next;
        for (int i = 0; i < plcl_pkg::NUM_CH; i++) begin
            val_reg[i] <= val_next[i];
        end
    end

    plcl_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .dxi     (seg_dxi_reg),
        .dx      (seg_dx_reg),
        .dy      (seg_dy_reg),
        .ya      (seg_ya_reg),
        .done    (unit_done),
        .value   (unit_value)
    );

endmodule

// ----- hw/rtl/plcl_interp.sv -----
// Shared interpolation unit: one multiply, then a one-bit-per-cycle restoring divide.
module plcl_interp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [plcl_pkg::DX_W-1:0]         dxi,     // index minus segment start
    input  logic [plcl_pkg::X_W-1:0]          dx,      // segment width, nonzero
    input  logic signed [plcl_pkg::DY_W-1:0]  dy,      // yb - ya
    input  logic [plcl_pkg::Y_W-1:0]          ya,
    output logic                              done,
    output logic [plcl_pkg::Y_W-1:0]          value
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_DONE = 2'd3;

    localparam int QC_W = $clog2(plcl_pkg::Y_W);

    logic [1:0]                  state_reg, state_next;
    logic [plcl_pkg::DX_W-1:0]   dxi_reg, dxi_next;
    logic [plcl_pkg::Y_W-1:0]    mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic [plcl_pkg::X_W-1:0]    dx_reg, dx_next;
    logic [plcl_pkg::Y_W-1:0]    ya_reg, ya_next;
    logic [plcl_pkg::X_W-1:0]    rem_reg, rem_next;
    logic [plcl_pkg::Y_W-1:0]    num_reg, num_next;
    logic [plcl_pkg::Y_W-1:0]    quo_reg, quo_next;
    logic [QC_W-1:0]             cnt_reg, cnt_next;

    logic [plcl_pkg::PROD_W-1:0] prod;
    logic [plcl_pkg::X_W:0]      trial;
    logic                        ge;
    logic [plcl_pkg::DY_W-1:0]   dy_abs;

    assign dy_abs = dy[plcl_pkg::DY_W-1] ? -dy : dy;
    assign prod   = plcl_pkg::PROD_W'(dxi_reg) * plcl_pkg::PROD_W'(mag_reg);
    assign trial  = {rem_reg, num_reg[plcl_pkg::Y_W-1]};
    assign ge     = trial >= {1'b0, dx_reg};

    // Sign applied after the magnitude divide truncates toward zero
    assign done  = (state_reg == U_DONE);
    assign value = neg_reg ? (ya_reg - quo_reg) : (ya_reg + quo_reg);

    always_comb begin
        state_next = state_reg;
        dxi_next   = dxi_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        dx_next    = dx_reg;
        ya_next    = ya_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    dxi_next   = dxi;
                    mag_next   = plcl_pkg::Y_W'(dy_abs);
                    neg_next   = dy[plcl_pkg::DY_W-1];
                    dx_next    = dx;
                    ya_next    = ya;
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                // Quotient stays below 2^Y_W, so the upper product bits start below dx
                rem_next   = plcl_pkg::X_W'(prod[plcl_pkg::PROD_W-1:plcl_pkg::Y_W]);
                num_next   = prod[plcl_pkg::Y_W-1:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = U_DIV;
            end
            U_DIV: begin
                rem_next = ge ? plcl_pkg::X_W'(trial - {1'b0, dx_reg})
                              : trial[plcl_pkg::X_W-1:0];
                num_next = {num_reg[plcl_pkg::Y_W-2:0], 1'b0};
                quo_next = {quo_reg[plcl_pkg::Y_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == QC_W'(plcl_pkg::Y_W - 1)) begin
                    state_next = U_DONE;
                end
            end
            U_DONE: begin
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
        dxi_reg <= dxi_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        dx_reg  <= dx_next;
        ya_reg  <= ya_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

endmodule
